// ----- hw/rtl/hffa_pkg.sv -----
package hffa_pkg;

  localparam int HEAP_BYTES    = 1048576;
  localparam int GRANULE_BYTES = 16;
  localparam int PAGE_BYTES    = 4096;
  localparam int HEADER_BYTES  = 16;

  localparam int NSLOTS = HEAP_BYTES / GRANULE_BYTES;
  localparam int SLOT_W = $clog2(NSLOTS);
  localparam int GSH    = $clog2(GRANULE_BYTES);
  localparam int PSH    = $clog2(PAGE_BYTES);
  // byte offsets up to and including the heap size
  localparam int BYTE_W = $clog2(HEAP_BYTES) + 1;
  // chunk size in granules, up to the whole heap
  localparam int SZG_W  = SLOT_W + 1;
  // rounded request, wide enough for the largest request plus header
  localparam int NEED_W = BYTE_W + 2;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [SZG_W-1:0]  size_g;
    logic [SLOT_W-1:0] prev;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic CFG_HEAP_LIMIT = 1'b0;
  localparam logic CFG_TAIL_LIMIT = 1'b1;

  function automatic logic [BYTE_W-1:0] sz_bytes(hdr_t h);
    return {h.size_g, {GSH{1'b0}}};
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [BYTE_W-1:0] a);
    return a[GSH +: SLOT_W];
  endfunction

  function automatic logic [SZG_W-1:0] to_gran(logic [BYTE_W-1:0] b);
    return b[GSH +: SZG_W];
  endfunction

endpackage

// ----- hw/rtl/hffa_ram.sv -----
module hffa_ram import hffa_pkg::*; #(
  parameter int WIDTH = HDR_W,
  parameter int DEPTH = NSLOTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/heap_first_fit_allocator.sv -----
// first-fit heap manager over one byte region
//
// command channel: an item is taken at a clock edge with start high and busy
// low. in_func selects allocate or free; in_req_size is used on allocate and
// in_free_addr on free. busy stays high until the result is out.
// result channel: out_valid is high for exactly one cycle per item with
// out_block_addr, out_status and out_heap_bytes_now; the receiver cannot stall
// and must take the result in that cycle.
// config port: cfg_we with cfg_index 0 (heap limit in pages) or 1 (free tail
// limit in bytes) writes cfg_wdata at once; write only while busy is low.
//
// after reset the chunk header memory is cleared, one slot a cycle, over all
// NSLOTS (65536) slots; busy is high during that pass.
// allocate walks chunk headers, issuing a read of each chunk (S_AW) and
// checking it (S_AWC), then splits off the rest and writes the taken header;
// a grow checks the tail against the limit, and a no-space result ends there.
// free checks the header and merges with free neighbours, then trims the
// tail; a free rejected on its address alone answers in the next cycle and
// busy stays low. one item at a time; the header memory read latency sets the pace.
module heap_first_fit_allocator import hffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [20:0]       in_req_size,
  input  logic [19:0]       in_free_addr,
  output logic              out_valid,
  output logic [19:0]       out_block_addr,
  output logic [1:0]        out_status,
  output logic [20:0]       out_heap_bytes_now,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [20:0]       cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLR,   // clearing pass over header memory
    S_IDLE,
    S_AW,    // walk: issue read of chunk at start
    S_AWC,   // walk: check chunk
    S_GC,    // grow: tail header in hand
    S_TSPL,  // take: split off rest
    S_TNW,   // take: fix prev of following chunk
    S_THD,   // take: write taken header
    S_FCK,   // free: check header
    S_BT,    // backward merge: issue read of predecessor
    S_BC,    // backward merge: check predecessor
    S_FT,    // forward merge: issue read at end
    S_FF,    // forward merge: check successor
    S_FD,    // write merged header
    S_FP,    // fix prev of chunk after merge
    S_TR,    // trim: read tail
    S_TC     // trim: check tail
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [BYTE_W-1:0]  heap_r, heap_nxt;
  logic [BYTE_W-1:0]  tail_r, tail_nxt;
  logic [8:0]         lim_pages_r;
  logic [20:0]        tail_lim_r;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic [BYTE_W-1:0]  start_r, start_nxt;   // chunk start, or first chunk of a merge
  logic [BYTE_W-1:0]  end_r, end_nxt;
  logic [BYTE_W-1:0]  hdr_r, hdr_nxt;
  hdr_t               cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [19:0]        out_addr_r, out_addr_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
  hdr_t               mem_wdata;
  logic [HDR_W-1:0]   mem_rdata;
  hdr_t               rd;

  hffa_ram #(
    .WIDTH(HDR_W),
    .DEPTH(NSLOTS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd = hdr_t'(mem_rdata);

  // shared datapath terms
  logic [BYTE_W-1:0]  rd_sz, cur_sz, rest, split_at, next_at, tb_sum, bound;
  logic [BYTE_W:0]    tail_end;
  logic [NEED_W-1:0]  need_in, g_amt;
  logic [NEED_W:0]    g_page, grow_sum, lim_b, lim_raw;
  logic [19:0]        hdr_in;

  assign rd_sz    = sz_bytes(rd);
  assign cur_sz   = sz_bytes(cur_r);
  assign need_in  = (NEED_W'(in_req_size) + NEED_W'(HEADER_BYTES + GRANULE_BYTES - 1))
                    & ~NEED_W'(GRANULE_BYTES - 1);
  assign g_amt    = rd.used ? need_r : need_r - NEED_W'(rd_sz);
  assign g_page   = ((NEED_W + 1)'(g_amt) + (NEED_W + 1)'(PAGE_BYTES - 1))
                    & ~(NEED_W + 1)'(PAGE_BYTES - 1);
  assign grow_sum = (NEED_W + 1)'(heap_r) + g_page;
  assign lim_raw  = (NEED_W + 1)'(lim_pages_r) << PSH;
  assign lim_b    = (lim_raw > (NEED_W + 1)'(HEAP_BYTES)) ? (NEED_W + 1)'(HEAP_BYTES)
                                                          : lim_raw;
  assign rest     = cur_sz - BYTE_W'(need_r);
  assign split_at = start_r + BYTE_W'(need_r);
  assign next_at  = start_r + cur_sz;
  assign hdr_in   = in_free_addr - 20'(HEADER_BYTES);
  assign tb_sum   = tail_r + BYTE_W'(HEADER_BYTES);
  assign bound    = (tb_sum & ~BYTE_W'(PAGE_BYTES - 1)) + BYTE_W'(PAGE_BYTES);
  assign tail_end = (BYTE_W + 1)'(tail_r) + (BYTE_W + 1)'(rd_sz);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    heap_nxt       = heap_r;
    tail_nxt       = tail_r;
    need_nxt       = need_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    hdr_nxt        = hdr_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        if (clr_cnt_r == '0) begin
          // one free page chunk at offset zero
          mem_wdata.valid  = 1'b1;
          mem_wdata.size_g = to_gran(BYTE_W'(PAGE_BYTES));
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_W'(NSLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_func == FN_ALLOC) begin
            need_nxt  = need_in;
            start_nxt = '0;
            state_nxt = S_AW;
          end else if (in_free_addr < 20'(HEADER_BYTES) ||
                       BYTE_W'(hdr_in) >= heap_r ||
                       hdr_in[GSH-1:0] != '0) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = ST_BAD_FREE;
          end else begin
            hdr_nxt   = BYTE_W'(hdr_in);
            mem_raddr = slot_of(BYTE_W'(hdr_in));
            state_nxt = S_FCK;
          end
        end
      end

      S_AW: begin
        if (start_r >= heap_r) begin
          mem_raddr = slot_of(tail_r);
          state_nxt = S_GC;
        end else begin
          mem_raddr = slot_of(start_r);
          state_nxt = S_AWC;
        end
      end

      S_AWC: begin
        if (!rd.valid || rd.size_g == '0) begin
          mem_raddr = slot_of(tail_r);
          state_nxt = S_GC;
        end else if (!rd.used && NEED_W'(rd_sz) >= need_r) begin
          cur_nxt   = rd;
          state_nxt = S_TSPL;
        end else begin
          start_nxt = start_r + rd_sz;
          state_nxt = S_AW;
        end
      end

      S_GC: begin
        if (grow_sum > lim_b) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = ST_NO_SPACE;
          state_nxt      = S_IDLE;
        end else begin
          if (rd.used) begin
            // new free chunk at the old heap end
            cur_nxt.valid  = 1'b1;
            cur_nxt.used   = 1'b0;
            cur_nxt.size_g = to_gran(BYTE_W'(g_page));
            cur_nxt.prev   = slot_of(tail_r);
            start_nxt      = heap_r;
            tail_nxt       = heap_r;
          end else begin
            cur_nxt        = rd;
            cur_nxt.size_g = rd.size_g + to_gran(BYTE_W'(g_page));
            start_nxt      = tail_r;
          end
          heap_nxt  = BYTE_W'(grow_sum);
          state_nxt = S_TSPL;
        end
      end

      S_TSPL: begin
        state_nxt = S_THD;
        if (rest >= BYTE_W'(HEADER_BYTES)) begin
          mem_we           = 1'b1;
          mem_waddr        = slot_of(split_at);
          mem_wdata.valid  = 1'b1;
          mem_wdata.size_g = to_gran(rest);
          mem_wdata.prev   = slot_of(start_r);
          if (tail_r == start_r) begin
            tail_nxt = split_at;
          end
          cur_nxt.size_g = to_gran(BYTE_W'(need_r));
          end_nxt        = next_at;
          if (next_at < heap_r) begin
            mem_raddr = slot_of(next_at);
            state_nxt = S_TNW;
          end
        end
      end

      S_TNW: begin
        mem_we         = 1'b1;
        mem_waddr      = slot_of(end_r);
        mem_wdata      = rd;
        mem_wdata.prev = slot_of(split_at);
        state_nxt      = S_THD;
      end

      S_THD: begin
        mem_we         = 1'b1;
        mem_waddr      = slot_of(start_r);
        mem_wdata      = cur_r;
        mem_wdata.used = 1'b1;
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = 20'(start_r + BYTE_W'(HEADER_BYTES));
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end

      S_FCK: begin
        if (!rd.valid || !rd.used) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = ST_BAD_FREE;
          state_nxt      = S_IDLE;
        end else begin
          cur_nxt      = rd;
          cur_nxt.used = 1'b0;
          start_nxt    = hdr_r;
          end_nxt      = hdr_r + rd_sz;
          state_nxt    = S_BT;
        end
      end

      S_BT: begin
        if (start_r == '0) begin
          state_nxt = S_FT;
        end else begin
          mem_raddr = cur_r.prev;
          state_nxt = S_BC;
        end
      end

      S_BC: begin
        if (rd.used) begin
          state_nxt = S_FT;
        end else begin
          // absorb current first chunk into its free predecessor
          mem_we          = 1'b1;
          mem_waddr       = slot_of(start_r);
          mem_wdata       = cur_r;
          mem_wdata.valid = 1'b0;
          start_nxt       = BYTE_W'({cur_r.prev, {GSH{1'b0}}});
          cur_nxt         = rd;
          state_nxt       = S_BT;
        end
      end

      S_FT: begin
        if (end_r >= heap_r) begin
          state_nxt = S_FD;
        end else begin
          mem_raddr = slot_of(end_r);
          state_nxt = S_FF;
        end
      end

      S_FF: begin
        if (rd.used || rd.size_g == '0) begin
          state_nxt = S_FD;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = slot_of(end_r);
          mem_wdata       = rd;
          mem_wdata.valid = 1'b0;
          if (tail_r == end_r) begin
            tail_nxt = start_r;
          end
          end_nxt   = end_r + rd_sz;
          state_nxt = S_FT;
        end
      end

      S_FD: begin
        if (tail_r == hdr_r) begin
          tail_nxt = start_r;
        end
        mem_we           = 1'b1;
        mem_waddr        = slot_of(start_r);
        mem_wdata        = cur_r;
        mem_wdata.valid  = 1'b1;
        mem_wdata.size_g = to_gran(end_r - start_r);
        if (end_r < heap_r) begin
          mem_raddr = slot_of(end_r);
          state_nxt = S_FP;
        end else begin
          state_nxt = S_TR;
        end
      end

      S_FP: begin
        mem_we         = 1'b1;
        mem_waddr      = slot_of(end_r);
        mem_wdata      = rd;
        mem_wdata.prev = slot_of(start_r);
        state_nxt      = S_TR;
      end

      S_TR: begin
        mem_raddr = slot_of(tail_r);
        state_nxt = S_TC;
      end

      S_TC: begin
        // trim a large free tail back to the page after its header
        if (!rd.used && rd_sz > tail_lim_r &&
            (BYTE_W + 1)'(bound) < tail_end) begin
          mem_we           = 1'b1;
          mem_waddr        = slot_of(tail_r);
          mem_wdata        = rd;
          mem_wdata.size_g = to_gran(bound - tail_r);
          heap_nxt         = bound;
        end
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = '0;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      heap_r      <= BYTE_W'(PAGE_BYTES);
      tail_r      <= '0;
      lim_pages_r <= 9'd256;
      tail_lim_r  <= 21'd8192;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      heap_r      <= heap_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_LIMIT: lim_pages_r <= cfg_wdata[8:0];
          CFG_TAIL_LIMIT: tail_lim_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    need_r       <= need_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    hdr_r        <= hdr_nxt;
    cur_r        <= cur_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_block_addr     = out_addr_r;
  assign out_status         = out_status_r;
  assign out_heap_bytes_now = 21'(heap_r);

  // a result comes out only as the block returns to idle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while block busy");

  // an accepted item keeps the block busy next cycle or answers at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("item accepted but block not busy");

  // failed items report no address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_addr_r == '0)
    else $error("address on failed item");

  // heap size stays within the region and never drops to zero
  a_heap_range: assert property (@(posedge clk) disable iff (!rst_n)
    heap_r != '0 && heap_r <= BYTE_W'(HEAP_BYTES))
    else $error("heap size out of range");

endmodule
